// ===== rtl/ctd_pkg.sv =====
// Shared constants for the chunked transfer decoder: size width and status codes.
// No dependencies; used by the result interface, the top level and the checker.
package ctd_pkg;

   localparam int SIZE_BITS = 32;
   localparam int STATUS_W  = 3;

   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SIZE_EOL = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY_LINE  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_HEX      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DATA_SHORT  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NO_DATA_EOL = 3'd5;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 3'd6;

endpackage

// ===== rtl/ctd_req_if.sv =====
// Input channel of the chunked transfer decoder: one encoded byte per transaction.
// Depends on nothing but the valid/ready handshake.
interface ctd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== rtl/ctd_rsp_if.sv =====
// Result channel of the chunked transfer decoder: decoded byte and/or end status.
// Depends on ctd_pkg for the status width.
interface ctd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         data_valid;
   logic [7:0]                   data_byte;
   logic                         end_valid;
   logic [ctd_pkg::STATUS_W-1:0] status;

   modport source (output valid, output data_valid, output data_byte, output end_valid,
                   output status, input ready);
   modport sink   (input valid, input data_valid, input data_byte, input end_valid,
                   input status, output ready);
endinterface

// ===== rtl/chunked_transfer_decoder.sv =====
// Chunked transfer decoder top level: size line parser, data pass-through, result queue.
// Depends on ctd_pkg, ctd_req_if and ctd_rsp_if.
//
// Usage:
//   req_if carries the chunk-encoded body, one byte per transaction, with in_last on
//   the final byte. rsp_if carries decoded data bytes (data_valid) and, once per body,
//   an end report (end_valid with status). A byte that yields neither gives no
//   transaction; a data byte with in_last gives one transaction carrying both.
//   Each accepted byte is decoded in the cycle it is accepted; its result is registered
//   into the result queue, whose head drives rsp_if, so throughput is 1 byte per
//   cycle while the receiver keeps up.
//   A two-entry result queue holds results; req_if.ready comes from the queue count and
//   drops only when both entries are full. While results keep coming, receiver stalls
//   fill the queue, and a full queue holds off input.
//   After the end report, bytes are swallowed until in_last, which rearms the parser.
//   Reset (synchronous) empties the queue and returns the parser to the start of a
//   size line; no clearing pass is needed.
module chunked_transfer_decoder (
   input logic       clock,
   input logic       reset,
   ctd_req_if.sink   req_if,
   ctd_rsp_if.source rsp_if
);

   localparam int SB = ctd_pkg::SIZE_BITS;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_X_LO  = 8'h78;
   localparam logic [7:0] CH_X_UP  = 8'h58;

   typedef enum logic [2:0] {
      PH_LINE, PH_DATA, PH_DATA_CR, PH_DATA_LF, PH_DRAIN
   } phase_type;

   typedef enum logic [2:0] {
      NP_WS, NP_ZERO, NP_PREFIX, NP_DIGITS, NP_STOP, NP_NODIGIT, NP_OVERFLOW
   } num_phase_type;

   typedef struct packed {
      num_phase_type np;
      logic [SB-1:0] bl;
   } num_type;

   typedef struct packed {
      logic                         data_valid;
      logic [7:0]                   data_byte;
      logic                         end_valid;
      logic [ctd_pkg::STATUS_W-1:0] status;
   } rsp_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
             (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
   endfunction

   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
      else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
         r = {1'b1, c[3:0] + 4'd9};
      return r;
   endfunction

   function automatic num_type add_digit(input logic [SB-1:0] bl, input logic [3:0] d);
      num_type r;
      r.bl = bl;
      r.np = NP_OVERFLOW;
      if (bl[SB-1 -: 4] == 4'd0) begin
         r.bl = {bl[SB-5:0], d};
         r.np = NP_DIGITS;
      end
      return r;
   endfunction

   function automatic num_type feed(input num_type cur, input logic [7:0] c);
      num_type    r;
      logic [4:0] h;
      r = cur;
      h = hex_val(c);
      unique case (cur.np)
         NP_WS: begin
            if (is_ws(c)) begin
               r = cur;
            end else if (c == CH_ZERO) begin
               r.bl = '0;
               r.np = NP_ZERO;
            end else if (h[4]) begin
               r = add_digit('0, h[3:0]);
            end else begin
               r.np = NP_NODIGIT;
            end
         end
         NP_ZERO: begin
            if (c == CH_X_LO || c == CH_X_UP) r.np = NP_PREFIX;
            else if (h[4]) r = add_digit(cur.bl, h[3:0]);
            else r.np = NP_STOP;
         end
         NP_PREFIX, NP_DIGITS: begin
            if (h[4]) r = add_digit(cur.bl, h[3:0]);
            else r.np = NP_STOP;
         end
         default: r = cur;
      endcase
      return r;
   endfunction

   phase_type     phase_ff, phase_in;
   num_type       num_ff, num_in;
   logic          line_nonempty_ff, line_nonempty_in;
   logic          pending_cr_ff, pending_cr_in;

   rsp_type       res;
   logic          req_take;
   logic          push;
   logic          pop;

   rsp_type       head_ff, tail_ff;
   logic [1:0]    count_ff, count_in;

   assign req_take = req_if.valid && req_if.ready;
   assign push     = req_take && (res.data_valid || res.end_valid);
   assign pop      = rsp_if.valid && rsp_if.ready;

   always_comb begin
      num_type    nm;
      logic [7:0] c;
      c                = req_if.in_byte;
      phase_in         = phase_ff;
      nm               = num_ff;
      line_nonempty_in = line_nonempty_ff;
      pending_cr_in    = pending_cr_ff;
      res              = '0;
      unique case (phase_ff)
         PH_LINE: begin
            if (pending_cr_ff && c == CH_LF) begin
               pending_cr_in = 1'b0;
               res.end_valid = 1'b1;
               if (!line_nonempty_ff) res.status = ctd_pkg::ST_EMPTY_LINE;
               else if (num_ff.np == NP_WS || num_ff.np == NP_NODIGIT)
                  res.status = ctd_pkg::ST_NO_HEX;
               else if (num_ff.np == NP_OVERFLOW) res.status = ctd_pkg::ST_OVERFLOW;
               else if (num_ff.bl == '0) res.status = ctd_pkg::ST_OK;
               else begin
                  res.end_valid = 1'b0;
                  phase_in      = PH_DATA;
               end
               if (res.end_valid) phase_in = PH_DRAIN;
            end else begin
               if (pending_cr_ff) begin
                  nm               = feed(nm, CH_CR);
                  line_nonempty_in = 1'b1;
               end
               pending_cr_in = (c == CH_CR);
               if (c != CH_CR) begin
                  nm               = feed(nm, c);
                  line_nonempty_in = 1'b1;
               end
            end
         end
         PH_DATA: begin
            res.data_valid = 1'b1;
            res.data_byte  = c;
            nm.bl          = num_ff.bl - SB'(1);
            if (num_ff.bl == SB'(1)) phase_in = PH_DATA_CR;
         end
         PH_DATA_CR: begin
            if (c == CH_CR) phase_in = PH_DATA_LF;
            else begin
               res.end_valid = 1'b1;
               res.status    = ctd_pkg::ST_NO_DATA_EOL;
               phase_in      = PH_DRAIN;
            end
         end
         PH_DATA_LF: begin
            if (c == CH_LF) begin
               phase_in         = PH_LINE;
               nm.bl            = '0;
               nm.np            = NP_WS;
               line_nonempty_in = 1'b0;
               pending_cr_in    = 1'b0;
            end else begin
               res.end_valid = 1'b1;
               res.status    = ctd_pkg::ST_NO_DATA_EOL;
               phase_in      = PH_DRAIN;
            end
         end
         default: phase_in = PH_DRAIN;
      endcase

      if (req_if.in_last) begin
         if (phase_in != PH_DRAIN) begin
            res.end_valid = 1'b1;
            if (phase_in == PH_LINE)
               res.status = (line_nonempty_in || pending_cr_in) ?
                            ctd_pkg::ST_NO_SIZE_EOL : ctd_pkg::ST_OK;
            else if (phase_in == PH_DATA) res.status = ctd_pkg::ST_DATA_SHORT;
            else res.status = ctd_pkg::ST_NO_DATA_EOL;
         end
         phase_in         = PH_LINE;
         nm.bl            = '0;
         nm.np            = NP_WS;
         line_nonempty_in = 1'b0;
         pending_cr_in    = 1'b0;
      end
      num_in = nm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_LINE;
         num_ff.np        <= NP_WS;
         num_ff.bl        <= '0;
         line_nonempty_ff <= 1'b0;
         pending_cr_ff    <= 1'b0;
      end else if (req_take) begin
         phase_ff         <= phase_in;
         num_ff           <= num_in;
         line_nonempty_ff <= line_nonempty_in;
         pending_cr_ff    <= pending_cr_in;
      end
   end

   // two-entry result queue, head drives the port
   assign count_in = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else       count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      if (pop && count_ff == 2'd2) begin
         head_ff <= tail_ff;
      end else if (push && (count_ff == 2'd0 || (pop && count_ff == 2'd1))) begin
         head_ff <= res;
      end
      if (push && count_ff == 2'd1 && !pop) tail_ff <= res;
   end

   assign req_if.ready      = (count_ff != 2'd2);
   assign rsp_if.valid      = (count_ff != 2'd0);
   assign rsp_if.data_valid = head_ff.data_valid;
   assign rsp_if.data_byte  = head_ff.data_byte;
   assign rsp_if.end_valid  = head_ff.end_valid;
   assign rsp_if.status     = head_ff.status;

endmodule

// ===== rtl/ctd_checker.sv =====
// Port-level checks for chunked_transfer_decoder, attached by the bind at the end.
// Depends on ctd_pkg for status codes; sees only the top level's ports.
module ctd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_data_valid,
   input logic [7:0]                   rsp_data_byte,
   input logic                         rsp_end_valid,
   input logic [ctd_pkg::STATUS_W-1:0] rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_data_byte) && $stable(rsp_end_valid))
      else $error("stalled transaction changed");

   a_rsp_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data_valid || rsp_end_valid)
      else $error("empty transaction");

   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_valid |-> rsp_status == ctd_pkg::ST_OK)
      else $error("status without end");

   a_data_end_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_valid && rsp_end_valid |->
         rsp_status == ctd_pkg::ST_DATA_SHORT || rsp_status == ctd_pkg::ST_NO_DATA_EOL)
      else $error("bad status on data with end");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result after reset");

endmodule

bind chunked_transfer_decoder ctd_checker u_ctd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_data_valid (rsp_if.data_valid),
   .rsp_data_byte  (rsp_if.data_byte),
   .rsp_end_valid  (rsp_if.end_valid),
   .rsp_status     (rsp_if.status)
);
